FILE: sv/rw_lock_writer_priority_arbiter_assert.svh
// Assertion macros for the reader/writer lock arbiter.
// Depends on nothing; included by the top level, which supplies clock and reset.
`ifndef RW_LOCK_WRITER_PRIORITY_ARBITER_ASSERT_SVH
`define RW_LOCK_WRITER_PRIORITY_ARBITER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge outside reset.
`define RWL_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked on every rising clock edge outside reset.
`define RWL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RWL_ASSERT_IMP(label, ante, cons, msg)
`define RWL_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: sv/rwlock_pkg.sv
// Shared constants and types for the reader/writer lock arbiter.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package rwlock_pkg;

   // Field widths of the request and response words.
   localparam int CMD_W  = 3;
   localparam int REQ_W  = 4;
   localparam int TMO_W  = 16;
   localparam int EV_W   = 2;

   // Number of requesters that may use the lock.
   localparam int NUM_REQUESTERS = 16;

   // Queue geometry and reader count limit.
   localparam int QIDX_W = 4;
   localparam int QCNT_W = QIDX_W + 1;
   localparam int QDEPTH = 1 << QIDX_W;
   localparam int RCNT_W = 5;
   localparam logic [RCNT_W-1:0] READER_MAX = 5'd31;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_ENTER_READ  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ENTER_WRITE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_EXIT_READ   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_EXIT_WRITE  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_TICK        = 3'd4;

   // Event codes.
   localparam logic [EV_W-1:0] EV_READ    = 2'd0;
   localparam logic [EV_W-1:0] EV_WRITE   = 2'd1;
   localparam logic [EV_W-1:0] EV_TIMEOUT = 2'd2;
   localparam logic [EV_W-1:0] EV_REJECT  = 2'd3;

   // One entry of the writer wait queue.
   typedef struct packed {
      logic [TMO_W-1:0] remain;
      logic [REQ_W-1:0] who;
   } wq_entry_type;

endpackage

`default_nettype wire

FILE: sv/rwlock_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on rwlock_pkg for the field widths.
`default_nettype none

// Request channel: command, requester and write wait limit.
interface rwlock_req_if;
   logic                             valid;
   logic                             ready;
   logic [rwlock_pkg::CMD_W-1:0]     command;
   logic [rwlock_pkg::REQ_W-1:0]     requester;
   logic [rwlock_pkg::TMO_W-1:0]     timeout_ms;

   modport source (output valid, command, requester, timeout_ms, input ready);
   modport sink   (input valid, command, requester, timeout_ms, output ready);
endinterface

// Response channel: event, requester concerned and end-of-reply mark.
interface rwlock_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [rwlock_pkg::EV_W-1:0]      event_res;
   logic [rwlock_pkg::REQ_W-1:0]     who;
   logic                             last;

   modport source (output valid, event_res, who, last, input ready);
   modport sink   (input valid, event_res, who, last, output ready);
endinterface

`default_nettype wire

FILE: sv/rw_lock_writer_priority_arbiter.sv
// Reader/writer lock arbiter with writer priority, run by a small sequencer.
// Depends on rwlock_pkg, rwlock_if.sv and rw_lock_writer_priority_arbiter_assert.svh.
//
//   channel    direction  carries
//   req_chan   in         command, requester, timeout_ms
//   rsp_chan   out        event_res, who, last (one word per event)
//
// A word is decided in S_EXEC; a waiting writer handed the lock passes through
// S_POP, queued readers are released in S_REL, and a tick walks the waiting
// writers in S_TICK and closes in S_TFIN. Each queue memory has one read
// port, so the walks move one entry per cycle unless a stalled response holds them.
// Synchronous reset clears the lock state and queue lengths; the queue
// memories are not cleared, since entries are only read below the length.
`default_nettype none

module rw_lock_writer_priority_arbiter (
   input wire logic         clock,
   input wire logic         reset,
   rwlock_req_if.sink       req_chan,
   rwlock_rsp_if.source     rsp_chan
);

`include "rw_lock_writer_priority_arbiter_assert.svh"

   // Sequencer state codes.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_POP  = 3'd2;
   localparam logic [2:0] S_REL  = 3'd3;
   localparam logic [2:0] S_TICK = 3'd4;
   localparam logic [2:0] S_TFIN = 3'd5;

   localparam int QIW = rwlock_pkg::QIDX_W;
   localparam int QCW = rwlock_pkg::QCNT_W;
   localparam int RQW = rwlock_pkg::REQ_W;

   // Control state.
   logic [2:0]                      state_ff, state_in;
   logic                            held_ff, held_in;
   logic [rwlock_pkg::RCNT_W-1:0]   rcount_ff, rcount_in;
   logic [QCW-1:0]                  rlen_ff, rlen_in;
   logic [QCW-1:0]                  wlen_ff, wlen_in;
   logic [QIW-1:0]                  whead_ff, whead_in;
   logic [QCW-1:0]                  idx_ff, idx_in;
   logic [QCW-1:0]                  k_ff, k_in;
   logic                            pend_valid_ff, pend_valid_in;
   logic [RQW-1:0]                  pend_who_ff, pend_who_in;

   // Latched request word.
   logic [rwlock_pkg::CMD_W-1:0]    cmd_ff;
   logic [RQW-1:0]                  req_ff;
   logic [rwlock_pkg::TMO_W-1:0]    tmo_ff;

   // Response register.
   logic                            rsp_valid_ff;
   logic [rwlock_pkg::EV_W-1:0]     rsp_ev_ff;
   logic [RQW-1:0]                  rsp_who_ff;
   logic                            rsp_last_ff;

   // Queue memories and their registered read data.
   logic [RQW-1:0]                  rq_mem [rwlock_pkg::QDEPTH];
   rwlock_pkg::wq_entry_type        wq_mem [rwlock_pkg::QDEPTH];
   logic [RQW-1:0]                  rq_rd_ff;
   rwlock_pkg::wq_entry_type        wq_rd_ff;

   // Memory write ports.
   logic                            rq_we;
   logic                            wq_we;
   logic [QIW-1:0]                  wq_waddr;
   rwlock_pkg::wq_entry_type        wq_wdata;
   logic [QIW-1:0]                  wq_raddr;

   // Response emit controls.
   logic                            emit;
   logic [rwlock_pkg::EV_W-1:0]     emit_ev;
   logic [RQW-1:0]                  emit_who;
   logic                            emit_last;
   logic                            emit_ok;

   // Decoded conditions.
   logic                            out_of_range;
   logic                            req_accept;
   logic [QCW-1:0]                  idx_next;
   logic [rwlock_pkg::TMO_W-1:0]    rem;

   assign req_chan.ready    = (state_ff == S_IDLE);
   assign req_accept        = req_chan.valid && req_chan.ready;
   assign emit_ok           = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.event_res = rsp_ev_ff;
   assign rsp_chan.who       = rsp_who_ff;
   assign rsp_chan.last      = rsp_last_ff;

   assign out_of_range = (cmd_ff <= rwlock_pkg::CMD_EXIT_WRITE) &&
                         ({5'd0, req_ff} >= 9'(rwlock_pkg::NUM_REQUESTERS));
   assign idx_next     = idx_ff + QCW'(1);
   assign rem          = wq_rd_ff.remain;
   assign wq_raddr     = whead_ff + idx_in[QIW-1:0];

   // Sequencer: decides commands; queue walks move one entry per cycle unless stalled.
   always_comb begin
      state_in      = state_ff;
      held_in       = held_ff;
      rcount_in     = rcount_ff;
      rlen_in       = rlen_ff;
      wlen_in       = wlen_ff;
      whead_in      = whead_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      pend_valid_in = pend_valid_ff;
      pend_who_in   = pend_who_ff;
      emit          = 1'b0;
      emit_ev       = rwlock_pkg::EV_REJECT;
      emit_who      = req_ff;
      emit_last     = 1'b1;
      rq_we         = 1'b0;
      wq_we         = 1'b0;
      wq_waddr      = whead_ff + wlen_ff[QIW-1:0];
      wq_wdata      = '{remain: tmo_ff, who: req_ff};

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_EXEC;
            end
         end

         // Decide the command; waits while the response register is occupied.
         S_EXEC: begin
            idx_in = '0;
            if (emit_ok) begin
               state_in = S_IDLE;
               if (out_of_range) begin
                  emit = 1'b1;
               end else begin
                  case (cmd_ff)
                     rwlock_pkg::CMD_ENTER_READ: begin
                        if (!held_ff && wlen_ff == '0) begin
                           emit = 1'b1;
                           if (rcount_ff != rwlock_pkg::READER_MAX) begin
                              rcount_in = rcount_ff + 5'd1;
                              emit_ev   = rwlock_pkg::EV_READ;
                           end
                        end else if (rlen_ff[QCW-1]) begin
                           emit = 1'b1;
                        end else begin
                           rq_we   = 1'b1;
                           rlen_in = rlen_ff + QCW'(1);
                        end
                     end
                     rwlock_pkg::CMD_ENTER_WRITE: begin
                        if (!held_ff && rcount_ff == '0) begin
                           held_in = 1'b1;
                           emit    = 1'b1;
                           emit_ev = rwlock_pkg::EV_WRITE;
                        end else if (wlen_ff[QCW-1]) begin
                           emit = 1'b1;
                        end else begin
                           wq_we   = 1'b1;
                           wlen_in = wlen_ff + QCW'(1);
                        end
                     end
                     rwlock_pkg::CMD_EXIT_READ: begin
                        if (rcount_ff != '0) begin
                           rcount_in = rcount_ff - 5'd1;
                           if (rcount_ff == 5'd1 && wlen_ff != '0) begin
                              held_in  = 1'b1;
                              state_in = S_POP;
                           end
                        end
                     end
                     rwlock_pkg::CMD_EXIT_WRITE: begin
                        if (held_ff) begin
                           held_in = 1'b0;
                           if (rlen_ff != '0) begin
                              state_in = S_REL;
                           end else if (wlen_ff != '0) begin
                              held_in  = 1'b1;
                              state_in = S_POP;
                           end
                        end
                     end
                     rwlock_pkg::CMD_TICK: begin
                        k_in          = '0;
                        pend_valid_in = 1'b0;
                        if (wlen_ff != '0) begin
                           state_in = S_TICK;
                        end
                     end
                     default: begin
                        state_in = S_IDLE;
                     end
                  endcase
               end
            end
         end

         // Hand the lock to the front writer.
         S_POP: begin
            if (emit_ok) begin
               emit     = 1'b1;
               emit_ev  = rwlock_pkg::EV_WRITE;
               emit_who = wq_rd_ff.who;
               whead_in = whead_ff + QIW'(1);
               wlen_in  = wlen_ff - QCW'(1);
               state_in = S_IDLE;
            end
         end

         // Release queued readers one per cycle while the response register can take them.
         S_REL: begin
            if (emit_ok) begin
               emit      = 1'b1;
               emit_ev   = rwlock_pkg::EV_READ;
               emit_who  = rq_rd_ff;
               emit_last = (idx_next == rlen_ff);
               idx_in    = idx_next;
               if (rcount_ff != rwlock_pkg::READER_MAX) begin
                  rcount_in = rcount_ff + 5'd1;
               end
               if (idx_next == rlen_ff) begin
                  rlen_in  = '0;
                  state_in = S_IDLE;
               end
            end
         end

         // Count down one waiting writer; an expired one is held back until the next
         // expiry or the tick's close, so the final timeout report can carry the end mark.
         S_TICK: begin
            if (rem == 16'd1) begin
               if (!pend_valid_ff || emit_ok) begin
                  emit          = pend_valid_ff;
                  emit_ev       = rwlock_pkg::EV_TIMEOUT;
                  emit_who      = pend_who_ff;
                  emit_last     = 1'b0;
                  pend_valid_in = 1'b1;
                  pend_who_in   = wq_rd_ff.who;
                  idx_in        = idx_next;
               end
            end else begin
               wq_we    = 1'b1;
               wq_waddr = whead_ff + k_ff[QIW-1:0];
               wq_wdata = '{remain: (rem == '0) ? rem : rem - 16'd1, who: wq_rd_ff.who};
               k_in     = k_ff + QCW'(1);
               idx_in   = idx_next;
            end
            if (idx_in == wlen_ff) begin
               state_in = S_TFIN;
            end
         end

         // Close the tick: new queue length and the last timeout report.
         S_TFIN: begin
            if (!pend_valid_ff || emit_ok) begin
               emit          = pend_valid_ff;
               emit_ev       = rwlock_pkg::EV_TIMEOUT;
               emit_who      = pend_who_ff;
               wlen_in       = k_ff;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         held_ff       <= 1'b0;
         rcount_ff     <= '0;
         rlen_ff       <= '0;
         wlen_ff       <= '0;
         whead_ff      <= '0;
         idx_ff        <= '0;
         k_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_ff       <= held_in;
         rcount_ff     <= rcount_in;
         rlen_ff       <= rlen_in;
         wlen_ff       <= wlen_in;
         whead_ff      <= whead_in;
         idx_ff        <= idx_in;
         k_ff          <= k_in;
         pend_valid_ff <= pend_valid_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: request word, response word and pending timeout.
   always_ff @(posedge clock) begin
      pend_who_ff <= pend_who_in;
      if (req_accept) begin
         cmd_ff <= req_chan.command;
         req_ff <= req_chan.requester;
         tmo_ff <= req_chan.timeout_ms;
      end
      if (emit) begin
         rsp_ev_ff   <= emit_ev;
         rsp_who_ff  <= emit_who;
         rsp_last_ff <= emit_last;
      end
   end

   // Reader queue memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (rq_we) begin
         rq_mem[rlen_ff[QIW-1:0]] <= req_ff;
      end
      rq_rd_ff <= rq_mem[idx_in[QIW-1:0]];
   end

   // Writer queue memory, kept as a ring from the head pointer.
   always_ff @(posedge clock) begin
      if (wq_we) begin
         wq_mem[wq_waddr] <= wq_wdata;
      end
      wq_rd_ff <= wq_mem[wq_raddr];
   end

   // The lock is never written and read at once.
   `RWL_ASSERT_IMP(a_excl, held_ff, rcount_ff == '0, "lock held by writer and readers")
   // Waiting writers imply the lock is busy whenever the sequencer rests.
   `RWL_ASSERT_IMP(a_wait_busy, (state_ff == S_IDLE) && (wlen_ff != '0),
                   held_ff || (rcount_ff != '0), "writers wait on a free lock")
   // Releasing readers happens only with the writer gone.
   `RWL_ASSERT_IMP(a_rel_free, state_ff == S_REL, !held_ff, "readers released under writer")
   // A closed tick leaves no pending timeout behind at rest.
   `RWL_ASSERT_NEXT(a_tfin, (state_ff == S_TFIN) && (state_in == S_IDLE),
                    !pend_valid_ff, "timeout report left pending")

endmodule

`default_nettype wire
